[hw/rtl/shortest_path_dense_graph_top_defines.svh]
// Assertion helpers for the shortest path block
`ifndef SHORTEST_PATH_DENSE_GRAPH_TOP_DEFINES_SVH
`define SHORTEST_PATH_DENSE_GRAPH_TOP_DEFINES_SVH

// same-cycle implication
`define SPDG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SPDG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/spdg_pkg.sv]
package spdg_pkg;
	localparam int NODE_W = 6;
	localparam int WIN_W = 16;
	localparam int COST_W = 22;
	localparam logic [COST_W-1:0] COST_MAX = '1;
	localparam int CFG_AW = 3;
	localparam int NCNT_W = 7;
	localparam logic [NCNT_W-1:0] NODE_COUNT_RST = 7'd64;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic REG_NODE_COUNT = 1'b0;
endpackage

[hw/rtl/shortest_path_dense_graph_top.sv]
// Dijkstra shortest path over a stored directed weight matrix. After reset the
// block sweeps all 2**(2*ceil(log2(MAX_NODES))) entries (4096 at 64 nodes)
// of the weight memory to "no edge", one entry a cycle, with in_stall high.
// An edge write gives no result. A query of n nodes runs up to n relax passes;
// each pass reads one matrix row through the single weight-memory read port,
// one entry a cycle; the block then walks the predecessors back and returns
// the path source first, one node per output transaction, each held while
// out_stall is high. One query is worked at a time; in_stall stays high until
// the last path node has been taken.
module shortest_path_dense_graph_top import spdg_pkg::*; #(
	parameter int MAX_NODES = 64,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                func,
	input  logic [NODE_W-1:0]   from_node,
	input  logic [NODE_W-1:0]   to_node,
	input  logic [WIN_W-1:0]    edge_weight,
	input  logic                edge_present,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [NODE_W-1:0]   path_node,
	output logic [COST_W-1:0]   total_cost,
	output logic                reachable,
	output logic                last,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [CFG_AW-1:0]   paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	localparam int NB = $clog2(MAX_NODES);
	localparam int CNT_W = $clog2(MAX_NODES + 1);
	localparam int WS = (WEIGHT_BITS < WIN_W) ? WEIGHT_BITS : WIN_W;
	localparam int MEM_AW = 2 * NB;
	localparam int MEM_D = 1 << MEM_AW;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_INIT, ST_RELAX, ST_NEXT, ST_TR_DIST, ST_TR_DCAP,
		ST_TR_LOOP, ST_TR_PCAP, ST_EM_RD, ST_EM_LD, ST_EM_WT
	} state_t;

	state_t state_q;

	// memories
	logic [WS:0]       wmem [MEM_D];
	logic [WS:0]       wmem_rd_q;
	logic              wmem_we;
	logic [MEM_AW-1:0] wmem_wa, wmem_ra;
	logic [WS:0]       wmem_wd;

	logic [COST_W-1:0] dmem [MAX_NODES];
	logic [COST_W-1:0] dmem_rd_q, dmem_wd;
	logic              dmem_we;
	logic [NB-1:0]     dmem_wa, dmem_ra;

	logic [NB-1:0]     pmem [MAX_NODES];
	logic [NB-1:0]     pmem_rd_q;
	logic              pmem_we;

	logic [NB-1:0]     bmem [MAX_NODES];
	logic [NB-1:0]     bmem_rd_q, bmem_wa, bmem_wd, bmem_ra;
	logic              bmem_we;

	// control
	logic [MEM_AW-1:0] clr_q;
	logic [NCNT_W-1:0] node_count_q;
	logic [CNT_W-1:0]  n_q, vi_q, k_q, cnt_q, i_q;
	logic [NB-1:0]     src_q, dst_q, u_q, cand_q, node_q, v_s1;
	logic [COST_W-1:0] bestd_q, candd_q, cost_q;
	logic              found_q, vld_s1;
	logic [MAX_NODES-1:0] disc_q, set_q;
	logic              out_valid_q, reach_q, last_q;
	logic [NODE_W-1:0] path_node_q;
	logic [COST_W-1:0] total_cost_q;

	logic              in_acc, cfg_wr, issue, edge_ok, disc_v, upd, new_disc, take;
	logic              wr_ok, q_ok;
	logic [CNT_W-1:0]  n_eff;
	logic [COST_W:0]   sum_w;
	logic [COST_W-1:0] relax_c, new_d;
	logic [CNT_W-1:0]  rd_pos;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_NODE_COUNT);
	assign prdata = (paddr[2] == REG_NODE_COUNT) ? 32'(node_count_q) : '0;

	assign out_valid = out_valid_q;
	assign path_node = path_node_q;
	assign total_cost = total_cost_q;
	assign reachable = reach_q;
	assign last = last_q;

	always_comb begin
		if (node_count_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (node_count_q > NCNT_W'(MAX_NODES)) begin
			n_eff = CNT_W'(MAX_NODES);
		end else begin
			n_eff = CNT_W'(node_count_q);
		end
	end

	assign wr_ok = (NCNT_W'(from_node) < NCNT_W'(MAX_NODES))
		&& (NCNT_W'(to_node) < NCNT_W'(MAX_NODES));
	assign q_ok = (NCNT_W'(from_node) < NCNT_W'(n_eff))
		&& (NCNT_W'(to_node) < NCNT_W'(n_eff));

	// relax datapath: one matrix entry per cycle
	assign issue = (state_q == ST_RELAX) && (vi_q < n_q);
	assign sum_w = {1'b0, bestd_q} + (COST_W + 1)'(wmem_rd_q[WS-1:0]);
	assign relax_c = sum_w[COST_W] ? COST_MAX : sum_w[COST_W-1:0];
	assign edge_ok = vld_s1 && wmem_rd_q[WS] && (v_s1 != u_q);
	assign disc_v = disc_q[v_s1];
	assign upd = edge_ok && (!disc_v || (relax_c < dmem_rd_q));
	assign new_d = upd ? relax_c : dmem_rd_q;
	assign new_disc = disc_v || edge_ok;
	// next node to settle, found while relaxing; strict less keeps lowest index
	assign take = vld_s1 && new_disc && !set_q[v_s1]
		&& (!found_q || (new_d < candd_q));

	always_comb begin
		wmem_we = 1'b0;
		wmem_wa = clr_q;
		wmem_wd = '0;
		if (state_q == ST_CLEAR) begin
			wmem_we = 1'b1;
		end else if (in_acc && func == FUNC_WRITE && wr_ok) begin
			wmem_we = 1'b1;
			wmem_wa = {from_node[NB-1:0], to_node[NB-1:0]};
			wmem_wd = {edge_present, edge_present ? edge_weight[WS-1:0] : WS'(0)};
		end
	end
	assign wmem_ra = {u_q, vi_q[NB-1:0]};

	always_comb begin
		dmem_we = upd;
		dmem_wa = v_s1;
		dmem_wd = relax_c;
		if (state_q == ST_INIT) begin
			dmem_we = 1'b1;
			dmem_wa = src_q;
			dmem_wd = '0;
		end
	end
	assign dmem_ra = (state_q == ST_RELAX) ? vi_q[NB-1:0] : dst_q;
	assign pmem_we = upd;

	assign bmem_we = (state_q == ST_TR_DCAP) || (state_q == ST_TR_PCAP);
	assign bmem_wa = (state_q == ST_TR_DCAP) ? '0 : k_q[NB-1:0];
	assign bmem_wd = (state_q == ST_TR_DCAP) ? dst_q : pmem_rd_q;
	assign rd_pos = cnt_q - i_q - CNT_W'(1);
	assign bmem_ra = rd_pos[NB-1:0];

	always_ff @(posedge clk) begin
		if (wmem_we) begin
			wmem[wmem_wa] <= wmem_wd;
		end
		wmem_rd_q <= wmem[wmem_ra];
		if (dmem_we) begin
			dmem[dmem_wa] <= dmem_wd;
		end
		dmem_rd_q <= dmem[dmem_ra];
		if (pmem_we) begin
			pmem[v_s1] <= u_q;
		end
		pmem_rd_q <= pmem[node_q];
		if (bmem_we) begin
			bmem[bmem_wa] <= bmem_wd;
		end
		bmem_rd_q <= bmem[bmem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			node_count_q <= NODE_COUNT_RST;
			n_q <= '0;
			vi_q <= '0;
			k_q <= '0;
			cnt_q <= '0;
			i_q <= '0;
			src_q <= '0;
			dst_q <= '0;
			u_q <= '0;
			cand_q <= '0;
			node_q <= '0;
			v_s1 <= '0;
			bestd_q <= '0;
			candd_q <= '0;
			cost_q <= '0;
			found_q <= 1'b0;
			vld_s1 <= 1'b0;
			disc_q <= '0;
			set_q <= '0;
			out_valid_q <= 1'b0;
			reach_q <= 1'b0;
			last_q <= 1'b0;
			path_node_q <= '0;
			total_cost_q <= '0;
		end else begin
			if (cfg_wr) begin
				node_count_q <= pwdata[NCNT_W-1:0];
			end
			vld_s1 <= issue;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + MEM_AW'(1);
					if (clr_q == MEM_AW'(MEM_D - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc && func == FUNC_QUERY) begin
						n_q <= n_eff;
						src_q <= from_node[NB-1:0];
						dst_q <= to_node[NB-1:0];
						if (q_ok) begin
							state_q <= ST_INIT;
						end else begin
							path_node_q <= to_node;
							total_cost_q <= '0;
							reach_q <= 1'b0;
							last_q <= 1'b1;
							out_valid_q <= 1'b1;
							state_q <= ST_EM_WT;
						end
					end
				end
				ST_INIT: begin
					disc_q <= MAX_NODES'(1) << src_q;
					set_q <= MAX_NODES'(1) << src_q;
					u_q <= src_q;
					bestd_q <= '0;
					found_q <= 1'b0;
					vi_q <= '0;
					state_q <= ST_RELAX;
				end
				ST_RELAX: begin
					if (issue) begin
						vi_q <= vi_q + CNT_W'(1);
						v_s1 <= vi_q[NB-1:0];
					end
					if (upd) begin
						disc_q[v_s1] <= 1'b1;
					end
					if (take) begin
						found_q <= 1'b1;
						cand_q <= v_s1;
						candd_q <= new_d;
					end
					if (!issue && !vld_s1) begin
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					if (found_q) begin
						u_q <= cand_q;
						bestd_q <= candd_q;
						set_q[cand_q] <= 1'b1;
						found_q <= 1'b0;
						vi_q <= '0;
						state_q <= ST_RELAX;
					end else if (disc_q[dst_q]) begin
						state_q <= ST_TR_DIST;
					end else begin
						path_node_q <= NODE_W'(dst_q);
						total_cost_q <= '0;
						reach_q <= 1'b0;
						last_q <= 1'b1;
						out_valid_q <= 1'b1;
						state_q <= ST_EM_WT;
					end
				end
				ST_TR_DIST: begin
					state_q <= ST_TR_DCAP;
				end
				ST_TR_DCAP: begin
					cost_q <= dmem_rd_q;
					node_q <= dst_q;
					k_q <= CNT_W'(1);
					state_q <= ST_TR_LOOP;
				end
				ST_TR_LOOP: begin
					if (node_q != src_q && k_q < n_q) begin
						state_q <= ST_TR_PCAP;
					end else begin
						cnt_q <= k_q;
						i_q <= '0;
						state_q <= ST_EM_RD;
					end
				end
				ST_TR_PCAP: begin
					node_q <= pmem_rd_q;
					k_q <= k_q + CNT_W'(1);
					state_q <= ST_TR_LOOP;
				end
				ST_EM_RD: begin
					state_q <= ST_EM_LD;
				end
				ST_EM_LD: begin
					path_node_q <= NODE_W'(bmem_rd_q);
					total_cost_q <= cost_q;
					reach_q <= 1'b1;
					last_q <= (i_q == cnt_q - CNT_W'(1));
					out_valid_q <= 1'b1;
					state_q <= ST_EM_WT;
				end
				ST_EM_WT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						if (last_q) begin
							state_q <= ST_IDLE;
						end else begin
							i_q <= i_q + CNT_W'(1);
							state_q <= ST_EM_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

[hw/rtl/spdg_checker.sv]
`include "shortest_path_dense_graph_top_defines.svh"

module spdg_checker import spdg_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [NODE_W-1:0] path_node,
	input logic [COST_W-1:0] total_cost,
	input logic              reachable,
	input logic              last
);
	// an unreachable answer is a single transaction with zero cost
	`SPDG_ASSERT_NOW(a_unreach_last, out_valid && !reachable, last, "unreachable not last")
	`SPDG_ASSERT_NOW(a_unreach_zero, out_valid && !reachable, total_cost == '0, "unreachable cost")
	// no input is taken while a path is being returned
	`SPDG_ASSERT_NOW(a_busy_out, out_valid, in_stall, "input open during output")
	`SPDG_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(path_node),
		"stalled output changed")
endmodule

bind shortest_path_dense_graph_top spdg_checker u_spdg_checker (.*);

[tb/shortest_path_checker.sv]
module shortest_path_checker import spdg_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic                func,
	input  logic [NODE_W-1:0]   from_node,
	input  logic [NODE_W-1:0]   to_node,
	input  logic [WIN_W-1:0]    edge_weight,
	input  logic                edge_present,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [NODE_W-1:0]   path_node,
	input  logic [COST_W-1:0]   total_cost,
	input  logic                reachable,
	input  logic                last,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic                pready,
	input  logic [CFG_AW-1:0]   paddr,
	input  logic [31:0]         pwdata,
	output int                  errors,
	output int                  pending
);
	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic [COST_W-1:0] cost;
		logic              reach;
		logic              last;
	} hop_t;

	localparam int NODES = 64;

	hop_t              expected_hops[$];
	bit                edge_set[NODES*NODES];
	logic [WIN_W-1:0]  edge_cost[NODES*NODES];
	logic [NCNT_W-1:0] nodes_cfg;

	initial begin
		errors = 0;
		nodes_cfg = NODE_COUNT_RST;
		for (int i = 0; i < NODES*NODES; i++) begin
			edge_set[i] = 0;
			edge_cost[i] = '0;
		end
	end

	assign pending = expected_hops.size();

	task automatic add_hop(input hop_t h);
		expected_hops.insert(expected_hops.size(), h);
	endtask

	// Dijkstra over the in-use nodes; least cost settled first, lowest index on ties,
	// predecessor only replaced on a strictly lower cost
	task automatic plan_route(input logic [NODE_W-1:0] src, input logic [NODE_W-1:0] dst);
		int n, u, k;
		bit found;
		logic [COST_W-1:0] cost_to[NODES];
		bit seen[NODES];
		bit done[NODES];
		int prev[NODES];
		int trail[NODES];
		logic [COST_W:0] sum;
		n = (nodes_cfg == 0) ? 1 : ((nodes_cfg > NODES) ? NODES : int'(nodes_cfg));
		if (src >= n || dst >= n) begin
			add_hop('{dst, '0, 1'b0, 1'b1});
			return;
		end
		for (int v = 0; v < NODES; v++) begin
			cost_to[v] = '0;
			seen[v] = 0;
			done[v] = 0;
			prev[v] = 0;
		end
		seen[src] = 1;
		forever begin
			found = 0;
			u = 0;
			for (int v = 0; v < n; v++)
				if (seen[v] && !done[v] && (!found || cost_to[v] < cost_to[u])) begin
					u = v;
					found = 1;
				end
			if (!found)
				break;
			done[u] = 1;
			for (int v = 0; v < n; v++) begin
				if (v == u || !edge_set[u*NODES+v])
					continue;
				sum = {1'b0, cost_to[u]} + (COST_W+1)'(edge_cost[u*NODES+v]);
				if (sum > {1'b0, COST_MAX})
					sum = {1'b0, COST_MAX};
				if (!seen[v] || sum[COST_W-1:0] < cost_to[v]) begin
					seen[v] = 1;
					cost_to[v] = sum[COST_W-1:0];
					prev[v] = u;
				end
			end
		end
		if (!seen[dst]) begin
			add_hop('{dst, '0, 1'b0, 1'b1});
			return;
		end
		k = 0;
		u = dst;
		trail[k++] = u;
		while (u != src && k < n) begin
			u = prev[u];
			trail[k++] = u;
		end
		for (int i = 0; i < k; i++)
			add_hop('{NODE_W'(trail[k-1-i]), cost_to[dst], 1'b1, logic'(i == k-1)});
	endtask

	always @(posedge clk) begin
		hop_t want;
		if (arst_n) begin
			if (psel && penable && pwrite && pready && paddr == {REG_NODE_COUNT, 2'b00})
				nodes_cfg <= pwdata[NCNT_W-1:0];
			if (in_valid && !in_stall) begin
				if (func == FUNC_WRITE) begin
					edge_set[from_node*NODES+to_node] = edge_present;
					edge_cost[from_node*NODES+to_node] = edge_present ? edge_weight : '0;
				end else
					plan_route(from_node, to_node);
			end
			if (out_valid && !out_stall) begin
				if (expected_hops.size() == 0) begin
					$error("unexpected path transaction, node %0d", path_node);
					errors++;
				end else begin
					want = expected_hops.pop_front();
					if (path_node !== want.node) begin
						$error("path_node expected %0d actual %0d", want.node, path_node);
						errors++;
					end
					if (total_cost !== want.cost) begin
						$error("total_cost expected %0d actual %0d", want.cost, total_cost);
						errors++;
					end
					if (reachable !== want.reach) begin
						$error("reachable expected %0d actual %0d", want.reach, reachable);
						errors++;
					end
					if (last !== want.last) begin
						$error("last expected %0d actual %0d", want.last, last);
						errors++;
					end
				end
			end
		end
	end
endmodule

[tb/testbench.sv]
module testbench;
	import spdg_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic func = FUNC_WRITE;
	logic [NODE_W-1:0] from_node = '0;
	logic [NODE_W-1:0] to_node = '0;
	logic [WIN_W-1:0] edge_weight = '0;
	logic edge_present = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [NODE_W-1:0] path_node;
	logic [COST_W-1:0] total_cost;
	logic reachable;
	logic last;
	logic psel = 0;
	logic penable = 0;
	logic pwrite = 0;
	logic [CFG_AW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	int errors;
	int pending;
	int cycles = 0;
	bit idle_on = 1;
	bit hold_req = 0;
	bit hold_done = 0;
	int hold_left = 0;
	int stall_left = 0;

	always #10 clk = ~clk;

	shortest_path_dense_graph_top DUT (.*);

	shortest_path_checker route_check (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: random stall bursts, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_req && !hold_done) begin
			hold_done <= 1;
			hold_left <= 300;
			out_stall <= 1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 2);
			out_stall <= 1;
		end else
			out_stall <= 0;
	end

	task automatic send_item(input logic f, input int a, input int b, input int w,
		input logic p);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid <= 1;
		func <= f;
		from_node <= NODE_W'(a);
		to_node <= NODE_W'(b);
		edge_weight <= WIN_W'(w);
		edge_present <= p;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic set_node_count(input int value);
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		psel <= 1;
		pwrite <= 1;
		paddr <= {REG_NODE_COUNT, 2'b00};
		pwdata <= 32'(value);
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	task automatic random_phase(input int n_eff, input int count);
		int a, b, w;
		for (int i = 0; i < count; i++) begin
			// mostly in-use nodes so queries walk real graphs
			if ($urandom_range(0, 9) < 9) begin
				a = $urandom_range(0, n_eff - 1);
				b = $urandom_range(0, n_eff - 1);
			end else begin
				a = $urandom_range(0, 63);
				b = $urandom_range(0, 63);
			end
			case ($urandom_range(0, 3))
				0: w = $urandom_range(0, 65535);
				1: w = $urandom_range(0, 1) ? 65535 : 0;
				default: w = $urandom_range(0, 50);
			endcase
			if ($urandom_range(0, 9) < 3)
				send_item(FUNC_QUERY, a, b, w, $urandom_range(0, 1));
			else
				send_item(FUNC_WRITE, a, b, w, $urandom_range(0, 9) < 8);
		end
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		send_item(FUNC_QUERY, 0, 5, 0, 0);        // empty graph: unreachable
		send_item(FUNC_QUERY, 3, 3, 0, 0);        // source is target
		send_item(FUNC_WRITE, 0, 1, 10, 1);
		send_item(FUNC_WRITE, 1, 2, 20, 1);
		send_item(FUNC_WRITE, 0, 2, 30, 1);       // equal cost, first predecessor kept
		send_item(FUNC_WRITE, 2, 2, 0, 1);        // self-loop, ignored by queries
		send_item(FUNC_WRITE, 2, 63, 65535, 1);
		send_item(FUNC_WRITE, 63, 0, 0, 1);
		hold_req = 1;
		send_item(FUNC_QUERY, 0, 63, 0, 0);
		send_item(FUNC_QUERY, 63, 2, 0, 0);
		send_item(FUNC_QUERY, 2, 1, 0, 0);
		send_item(FUNC_WRITE, 0, 2, 65535, 0);    // remove edge
		send_item(FUNC_QUERY, 0, 2, 0, 0);
		send_item(FUNC_QUERY, 62, 0, 0, 0);
		send_item(FUNC_WRITE, 5, 6, 0, 1);
		send_item(FUNC_QUERY, 5, 6, 65535, 1);
		set_node_count(8);
		send_item(FUNC_QUERY, 10, 1, 0, 0);       // source outside in-use range
		send_item(FUNC_QUERY, 0, 2, 0, 0);

		random_phase(8, 18);
		set_node_count(1);
		random_phase(1, 12);
		set_node_count(0);
		random_phase(1, 10);
		set_node_count(16);
		random_phase(16, 22);
		set_node_count(127);
		random_phase(64, 16);
		set_node_count(64);
		random_phase(64, 16);
		set_node_count(5);
		idle_on = 0;
		random_phase(5, 22);

		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
